/* sv/euler_angles_to_axis_vectors_core_assert.svh */
// Assertion macros for the euler axis vector core
`ifndef EULER_ANGLES_TO_AXIS_VECTORS_CORE_ASSERT_SVH
`define EULER_ANGLES_TO_AXIS_VECTORS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define EAV_ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define EAV_ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define EAV_ASSERT_IMPL(lbl, clk, rstn, a, c)
`define EAV_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

/* sv/eav_pkg.sv */
// ----------------------------------------------------------------------------
// eav_pkg
// Shared types, constants and helpers of the euler axis vector core.
// ----------------------------------------------------------------------------
`default_nettype none
package eav_pkg;
  localparam int AngleBits = 16;
  localparam int FracBits  = 14;
  localparam int Steps     = 31;
  localparam int FrontDepth = 4;
  localparam int PtrW       = 2;
  localparam logic signed [15:0] One = 16'sd16384;
  localparam logic [31:0] CordicGain = 32'd652032874;

  typedef struct packed {
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic [15:0] roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
  } out_t;

  // classified word handed from front to back: reduced turn and negate flag
  typedef struct packed {
    logic [2:0]        neg;
    logic signed [32:0] zx;
    logic signed [32:0] zy;
    logic signed [32:0] zz;
  } job_t;

  function automatic logic signed [32:0] atan_lut(input logic [4:0] i);
    logic signed [32:0] r;
    unique case (i)
      5'd0: r = 33'sd536870912;  5'd1: r = 33'sd316933406;
      5'd2: r = 33'sd167458907;  5'd3: r = 33'sd85004756;
      5'd4: r = 33'sd42667331;   5'd5: r = 33'sd21354465;
      5'd6: r = 33'sd10679838;   5'd7: r = 33'sd5340245;
      5'd8: r = 33'sd2670163;    5'd9: r = 33'sd1335087;
      5'd10: r = 33'sd667544;    5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;    5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;     5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;     5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;       5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;       5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;        5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;        5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;         5'd29: r = 33'sd1;
      5'd30: r = 33'sd1;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  // saturate a wide signed value to +-1.0
  function automatic logic signed [15:0] sat_unit(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd16384) r = One;
    else if (v < -36'sd16384) r = -One;
    else r = v[15:0];
    return r;
  endfunction

  // Q1.14 product, rounded half up
  function automatic logic signed [17:0] qmul(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b + 32'sd8192;
    return p[31:14];
  endfunction
endpackage
`default_nettype wire

/* sv/eav_front.sv */
// ----------------------------------------------------------------------------
// eav_front
// Half-turn fold of three angles into [-90, 90) degrees and a short job queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module eav_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire eav_pkg::in_t in_i,
  output logic              busy_o,
  input  wire logic         pop_i,
  output logic              avail_o,
  output eav_pkg::job_t     job_o
);
  eav_pkg::job_t            mem_q [eav_pkg::FrontDepth];
  logic [eav_pkg::PtrW-1:0] wp_q, rp_q;
  logic [eav_pkg::PtrW:0]   cnt_q, cnt_d;
  logic                     push;
  eav_pkg::job_t            job_w;

  function automatic void fold(input logic [15:0] a, output logic n,
                               output logic signed [32:0] z);
    logic [31:0] t;
    t = {a, 16'd0};
    n = t[31] ^ t[30];
    if (n) t = t + 32'h8000_0000;
    z = $signed({t[31], t});
  endfunction

  always_comb begin
    fold(in_i.pitch_angle, job_w.neg[0], job_w.zx);
    fold(in_i.yaw_angle,   job_w.neg[1], job_w.zy);
    fold(in_i.roll_angle,  job_w.neg[2], job_w.zz);
  end

  // back end pops every cycle it has a word, so the queue only absorbs phase
  assign busy_o  = (cnt_q == (eav_pkg::PtrW+1)'(eav_pkg::FrontDepth));
  assign push    = start_i && !busy_o;
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rp_q];
  assign cnt_d   = cnt_q + {{eav_pkg::PtrW{1'b0}}, push}
                 - {{eav_pkg::PtrW{1'b0}}, pop_i && avail_o};

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop_i && avail_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

`include "euler_angles_to_axis_vectors_core_assert.svh"
  `EAV_ASSERT_IMPL(a_no_over, clk_i, rst_ni, busy_o, !push)
  `EAV_ASSERT_NEXT(a_cnt, clk_i, rst_ni, push && !(pop_i && avail_o), cnt_q == $past(cnt_q) + 1'b1)
  `EAV_ASSERT_IMPL(a_bound, clk_i, rst_ni, 1'b1, cnt_q <= (eav_pkg::PtrW+1)'(eav_pkg::FrontDepth))
endmodule
`default_nettype wire

/* sv/eav_back.sv */
// ----------------------------------------------------------------------------
// eav_back
// Pipelined CORDIC, one stage per step, then rounding, product and sum stages.
// ----------------------------------------------------------------------------
`default_nettype none
module eav_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire eav_pkg::job_t job_i,
  output logic               vld_o,
  output eav_pkg::out_t      res_o
);
  localparam int N = eav_pkg::Steps;
  // entry i holds the state after step i
  logic signed [33:0] x_q [3][N];
  logic signed [33:0] y_q [3][N];
  logic signed [32:0] z_q [3][N];
  logic [2:0]         n_q [N];
  logic [N+3:0]       v_q;

  for (genvar i = 0; i < N; i++) begin : g_stage
    for (genvar a = 0; a < 3; a++) begin : g_ax
      logic signed [33:0] xs, ys;
      logic signed [32:0] zs;
      if (i == 0) begin : g_src
        assign xs = $signed({2'b00, eav_pkg::CordicGain});
        assign ys = '0;
        assign zs = (a == 0) ? job_i.zx : ((a == 1) ? job_i.zy : job_i.zz);
      end else begin : g_src
        assign xs = x_q[a][i-1];
        assign ys = y_q[a][i-1];
        assign zs = z_q[a][i-1];
      end
      always_ff @(posedge clk_i) begin
        if (!zs[32]) begin
          x_q[a][i] <= xs - (ys >>> i);
          y_q[a][i] <= ys + (xs >>> i);
          z_q[a][i] <= zs - eav_pkg::atan_lut(5'(i));
        end else begin
          x_q[a][i] <= xs + (ys >>> i);
          y_q[a][i] <= ys - (xs >>> i);
          z_q[a][i] <= zs + eav_pkg::atan_lut(5'(i));
        end
      end
    end
    if (i == 0) begin : g_neg
      always_ff @(posedge clk_i) n_q[i] <= job_i.neg;
    end else begin : g_neg
      always_ff @(posedge clk_i) n_q[i] <= n_q[i-1];
    end
  end

  // round Q30 to Q14, negate for folded angles, saturate
  function automatic logic signed [15:0] fin(input logic signed [33:0] v,
                                             input logic n);
    logic signed [33:0] w;
    logic signed [35:0] r;
    w = n ? -v : v;
    r = 36'(w + 34'sd32768) >>> 16;
    return eav_pkg::sat_unit(r);
  endfunction

  logic signed [15:0] s_q [3], c_q [3];
  logic signed [15:0] sxsy_q, cxsy_q, sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  logic signed [17:0] cycz_q, cxsz_q, sxsz_q, cysz_q, cxcz_q, sxcz_q, sxcy_q, cxcy_q;
  logic signed [17:0] sxsycz_q, cxsycz_q, sxsysz_q, cxsysz_q;
  logic signed [15:0] sy2_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      s_q[a] <= fin(y_q[a][N-1], n_q[N-1][a]);
      c_q[a] <= fin(x_q[a][N-1], n_q[N-1][a]);
    end
    sxsy_q <= 16'(eav_pkg::qmul(s_q[0], s_q[1]));
    cxsy_q <= 16'(eav_pkg::qmul(c_q[0], s_q[1]));
    sx_q <= s_q[0]; cx_q <= c_q[0]; sy_q <= s_q[1];
    cy_q <= c_q[1]; sz_q <= s_q[2]; cz_q <= c_q[2];
    cycz_q <= eav_pkg::qmul(cy_q, cz_q);
    cxsz_q <= eav_pkg::qmul(cx_q, sz_q);
    sxsz_q <= eav_pkg::qmul(sx_q, sz_q);
    cysz_q <= eav_pkg::qmul(cy_q, sz_q);
    cxcz_q <= eav_pkg::qmul(cx_q, cz_q);
    sxcz_q <= eav_pkg::qmul(sx_q, cz_q);
    sxcy_q <= eav_pkg::qmul(sx_q, cy_q);
    cxcy_q <= eav_pkg::qmul(cx_q, cy_q);
    // triple products: pair product times third factor, same stage
    sxsycz_q <= eav_pkg::qmul(sxsy_q, cz_q);
    cxsycz_q <= eav_pkg::qmul(cxsy_q, cz_q);
    sxsysz_q <= eav_pkg::qmul(sxsy_q, sz_q);
    cxsysz_q <= eav_pkg::qmul(cxsy_q, sz_q);
    sy2_q  <= sy_q;
    res_o.left_x    <= eav_pkg::sat_unit(36'(cycz_q));
    res_o.left_y    <= eav_pkg::sat_unit(36'(sxsycz_q) + 36'(cxsz_q));
    res_o.left_z    <= eav_pkg::sat_unit(36'(sxsz_q) - 36'(cxsycz_q));
    res_o.up_x      <= eav_pkg::sat_unit(-36'(cysz_q));
    res_o.up_y      <= eav_pkg::sat_unit(36'(cxcz_q) - 36'(sxsysz_q));
    res_o.up_z      <= eav_pkg::sat_unit(36'(cxsysz_q) + 36'(sxcz_q));
    res_o.forward_x <= sy2_q;
    res_o.forward_y <= eav_pkg::sat_unit(-36'(sxcy_q));
    res_o.forward_z <= eav_pkg::sat_unit(36'(cxcy_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[N+2:0], vld_i};
  end
  assign vld_o = v_q[N+3];

`include "euler_angles_to_axis_vectors_core_assert.svh"
  `EAV_ASSERT_NEXT(a_pipe, clk_i, rst_ni, vld_i, v_q[0])
  `EAV_ASSERT_IMPL(a_sat, clk_i, rst_ni, vld_o, res_o.left_x <= eav_pkg::One && res_o.left_x >= -eav_pkg::One)
  `EAV_ASSERT_IMPL(a_fwd, clk_i, rst_ni, vld_o, res_o.forward_z <= eav_pkg::One && res_o.forward_z >= -eav_pkg::One)
endmodule
`default_nettype wire

/* sv/euler_angles_to_axis_vectors_core.sv */
// Path from an accepted start to the done strobe: 1 queue stage, 31 CORDIC
// stages and 4 trig/product/sum stages. Throughput: one word per
// cycle, set by the fully pipelined CORDIC. The receiver cannot stall, so
// busy stays low in steady use. Reset is asynchronous, active low, and
// clears the queue and the valid pipeline.
// ----------------------------------------------------------------------------
// euler_angles_to_axis_vectors_core
// XYZ Euler angles to left, up and forward axis vectors in Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_angles_to_axis_vectors_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire eav_pkg::in_t in_i,
  output logic              done_o,
  output eav_pkg::out_t     res_o
);
  logic          avail;
  eav_pkg::job_t job;

  eav_front u_front (
    .clk_i, .rst_ni, .start_i(start), .in_i, .busy_o(busy),
    .pop_i(1'b1), .avail_o(avail), .job_o(job)
  );

  eav_back u_back (
    .clk_i, .rst_ni, .vld_i(avail), .job_i(job), .vld_o(done_o), .res_o
  );
endmodule
`default_nettype wire
